// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Every check is clocked on clk and is
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

// File: rtl/core/nccd_pkg.sv
// ---------------------------------------------------------------------------
// nccd_pkg
// Types, mode codes and bit tables shared by the cheat code decoder.
// ---------------------------------------------------------------------------
package nccd_pkg;

  // Mode codes
  localparam logic [1:0] MODE_SIX       = 2'd0;
  localparam logic [1:0] MODE_EIGHT     = 2'd1;
  localparam logic [1:0] MODE_KEYED     = 2'd2;
  localparam logic [1:0] MODE_KEYED_ALT = 2'd3;  // unused code, decodes as keyed

  // Request and response payloads
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] code_word;
  } req_t;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  value;
    logic        has_compare;
    logic [7:0]  compare;
  } rsp_t;

  // Letter-code gather tables, first entry lands in the MSB
  localparam logic [4:0] ADDR_PICK [15] = '{
    5'd14, 5'd13, 5'd12, 5'd19, 5'd22, 5'd21, 5'd20, 5'd7,
    5'd10, 5'd9,  5'd8,  5'd15, 5'd18, 5'd17, 5'd16
  };
  localparam logic [4:0] VAL_PICK [8] = '{
    5'd3, 5'd6, 5'd5, 5'd4, 5'd23, 5'd2, 5'd1, 5'd0
  };
  localparam logic [4:0] CMP_PICK [8] = '{
    5'd27, 5'd30, 5'd29, 5'd28, 5'd23, 5'd26, 5'd25, 5'd24
  };
  // Eight-letter codes take value bit 3 from here instead
  localparam logic [4:0] VAL_BIT3_EIGHT = 5'd31;

  // Keyed code constants
  localparam logic [31:0] KEY_SEED  = 32'h7E5E_E93A;
  localparam logic [31:0] KEY_STEP  = 32'h5C18_4B91;
  localparam logic [14:0] ADDR_MASK = 15'h7FFF;

  localparam logic [4:0] SCATTER [31] = '{
    5'd3,  5'd13, 5'd14, 5'd1,  5'd6,  5'd9,  5'd5,  5'd0,
    5'd12, 5'd7,  5'd2,  5'd8,  5'd10, 5'd11, 5'd4,
    5'd19, 5'd21, 5'd23, 5'd22, 5'd20, 5'd17, 5'd16, 5'd18,
    5'd29, 5'd31, 5'd24, 5'd26, 5'd25, 5'd30, 5'd27, 5'd28
  };

  typedef logic [31:0][30:0] kmat_t;

  // Bit-serial key schedule; used only at elaboration
  function automatic logic [31:0] key_loop(input logic [30:0] data);
    logic [31:0] key;
    logic [31:0] acc;
    logic [30:0] d;
    key = KEY_SEED;
    acc = '0;
    d   = data;
    for (int i = 30; i >= 0; i--) begin
      if (key[30] ^ d[30]) begin
        acc[SCATTER[i]] = 1'b1;
        key = key ^ KEY_STEP;
      end
      d   = {d[29:0], 1'b0};
      key = {key[30:0], 1'b0};
    end
    return acc;
  endfunction

  // The schedule is affine over GF(2): out = M * data ^ base.
  // Each column of M is the response to one data bit.
  function automatic kmat_t key_matrix();
    kmat_t       m;
    logic [30:0] unit;
    logic [31:0] col;
    logic [31:0] base;
    base = key_loop('0);
    for (int k = 0; k < 31; k++) begin
      unit    = '0;
      unit[k] = 1'b1;
      col     = key_loop(unit) ^ base;
      for (int j = 0; j < 32; j++) begin
        m[j][k] = col[j];
      end
    end
    return m;
  endfunction

  localparam logic [31:0] KEY_BASE   = key_loop('0);
  localparam kmat_t       KEY_MATRIX = key_matrix();

endpackage

// File: rtl/core/nccd_decode.sv
// ---------------------------------------------------------------------------
// nccd_decode
// Combinational decode of one cheat code request into a patch response.
// ---------------------------------------------------------------------------
module nccd_decode (
  input  nccd_pkg::req_t req,
  output nccd_pkg::rsp_t rsp
);
  import nccd_pkg::*;

  logic [14:0] ltr_addr;
  logic [7:0]  ltr_val;
  logic [7:0]  ltr_cmp;
  logic        is_eight;
  logic [30:0] kd;
  logic [31:0] kacc;

  // Letter codes: fixed bit gathers
  always_comb begin
    is_eight = (req.mode == MODE_EIGHT);
    for (int i = 0; i < 15; i++) begin
      ltr_addr[14 - i] = req.code_word[ADDR_PICK[i]];
    end
    for (int i = 0; i < 8; i++) begin
      ltr_val[7 - i] = req.code_word[VAL_PICK[i]];
      ltr_cmp[7 - i] = req.code_word[CMP_PICK[i]];
    end
    if (is_eight) begin
      ltr_val[3] = req.code_word[VAL_BIT3_EIGHT];
    end
  end

  // Keyed code: bit 0 dropped, key schedule folded into parity trees
  assign kd = req.code_word[31:1];

  always_comb begin
    for (int j = 0; j < 32; j++) begin
      kacc[j] = (^(kd & KEY_MATRIX[j])) ^ KEY_BASE[j];
    end
  end

  // Output select
  always_comb begin
    unique case (req.mode)
      MODE_SIX: begin
        rsp.address     = {1'b1, ltr_addr};
        rsp.value       = ltr_val;
        rsp.has_compare = 1'b0;
        rsp.compare     = '0;
      end
      MODE_EIGHT: begin
        rsp.address     = {1'b1, ltr_addr};
        rsp.value       = ltr_val;
        rsp.has_compare = 1'b1;
        rsp.compare     = ltr_cmp;
      end
      MODE_KEYED, MODE_KEYED_ALT: begin
        rsp.address     = {1'b1, kacc[14:0] & ADDR_MASK};
        rsp.value       = kacc[31:24];
        rsp.has_compare = 1'b1;
        rsp.compare     = kacc[23:16];
      end
    endcase
  end

endmodule

// File: rtl/core/nes_cheat_code_decoder.sv
// ---------------------------------------------------------------------------
// nes_cheat_code_decoder
// Cheat code decoder: letter and keyed codes to address, value and compare.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_ready / req) carries a mode and a 32-bit
//   packed code word. Response channel (rsp_valid / rsp_ready / rsp) returns
//   exactly one patch per request, in request order.
//   Path: a request accepted goes into the input register, is decoded, and
//   is then registered into the response register before it shows on rsp.
//   Throughput: one request per cycle while not stalled; the input register
//   feeds one pass of gather and parity-tree logic to the response register.
//   Stall: when rsp_ready is low, the response register holds; the input
//   register still takes one more request, then req_ready drops until the
//   response is taken. ready paths are combinational from rsp_ready.
//   Reset: synchronous rst clears both valid flags and holds req_ready low;
//   data registers are not reset; requests are taken as soon as rst is low.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nes_cheat_code_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  nccd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output nccd_pkg::rsp_t rsp
);
  import nccd_pkg::*;

  logic s1_valid;
  req_t s1;
  rsp_t dec;
  logic adv;

  // Handshake
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = !rst && (!s1_valid || adv);

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_ready) s1_valid <= req_valid;
      if (adv)       rsp_valid <= s1_valid;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) s1 <= req;
  end

  nccd_decode u_decode (
    .req (s1),
    .rsp (dec)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (adv && s1_valid) rsp <= dec;
  end

  // Checks
  `ASSERT_NOW(a_addr_high, rsp_valid, rsp.address[15])
  `ASSERT_NOW(a_no_cmp_zero, rsp_valid && !rsp.has_compare, rsp.compare == 8'd0)
  `ASSERT_NEXT(a_req_lands, req_valid && req_ready, s1_valid)
  `ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule
